>>> hw/rtl/anlp_pkg.sv
// ----------------------------------------------------------------------------
// anlp_pkg
// Shared types, constants and the power-of-ten table for the ASCII number
// literal parser.
// ----------------------------------------------------------------------------
package anlp_pkg;

	// Fraction digits kept; later digits are checked and dropped
	localparam int unsigned FRAC_DIGITS_MAX = 9;
	// Saturation bound of the exponent magnitude
	localparam int unsigned EXP_LIMIT = 10;

	// Result kinds
	localparam logic [1:0] KIND_ERR = 2'd0;
	localparam logic [1:0] KIND_INT = 2'd1;
	localparam logic [1:0] KIND_FIX = 2'd2;

	// Operand selection of the shared divider
	typedef enum logic [2:0] {
		SEL_FRAC,  // frac / 10^n gives integer carry and remainder
		SEL_R10,   // one decimal step of a positive exponent
		SEL_FIXF,  // fraction bits of the Q31.16 value
		SEL_WHOLE, // whole part over 10^e
		SEL_FIX    // fixed value over 10^e
	} div_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       clear;
		logic       add_int;
		logic       add_frac;
		logic       add_exp;
		logic [4:0] digit;
		logic [4:0] radix;
		logic       neg;
		logic       div_start;
		div_sel_t   div_sel;
		logic       out_load;
		logic       out_err;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic       div_done;
		logic       frac_nz;
		logic       q_ge_cap;
		logic [4:0] exp_val;
	} dp_stat_t;

	// 10^n for n up to 18
	function automatic logic [63:0] pow10(input logic [4:0] n);
		logic [63:0] p;
		unique case (n)
			5'd0:    p = 64'd1;
			5'd1:    p = 64'd10;
			5'd2:    p = 64'd100;
			5'd3:    p = 64'd1000;
			5'd4:    p = 64'd10000;
			5'd5:    p = 64'd100000;
			5'd6:    p = 64'd1000000;
			5'd7:    p = 64'd10000000;
			5'd8:    p = 64'd100000000;
			5'd9:    p = 64'd1000000000;
			5'd10:   p = 64'd10000000000;
			5'd11:   p = 64'd100000000000;
			5'd12:   p = 64'd1000000000000;
			5'd13:   p = 64'd10000000000000;
			5'd14:   p = 64'd100000000000000;
			5'd15:   p = 64'd1000000000000000;
			5'd16:   p = 64'd10000000000000000;
			5'd17:   p = 64'd100000000000000000;
			default: p = 64'd1000000000000000000;
		endcase
		return p;
	endfunction

endpackage

>>> hw/rtl/ascii_number_literal_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_number_literal_parser_core
// Parses ASCII number literals one character at a time into integer and
// Q31.16 fixed-point results.
// ----------------------------------------------------------------------------
// A character other than NUL yields no result. The NUL terminator yields one
// result: a malformed literal goes from the terminator straight to the output
// state. Otherwise the single shared bit-serial divider makes one pass that
// scales the fraction, one pass for each positive exponent step (up to the
// exponent value, fewer once the integer part reaches 2^40) and one more pass
// for the Q31.16 fraction bits. A negative exponent skips the steps and adds
// two back-to-back passes over the power of ten. A result is loaded only once
// the output register is free. Characters of the next literal are taken while
// a result waits on the output.
module ascii_number_literal_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         ch,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic signed [31:0] int_value,
	output logic signed [47:0] fixed_value
);

	anlp_pkg::dp_cmd_t  cmd;
	anlp_pkg::dp_stat_t stat;

	anlp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	anlp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.int_value   (int_value),
		.fixed_value (fixed_value)
	);

endmodule

>>> hw/rtl/anlp_div.sv
// ----------------------------------------------------------------------------
// anlp_div
// Restoring unsigned divider, 64 by 64 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module anlp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo,
	output logic [63:0] rem
);

	logic [63:0] n_q;
	logic [63:0] d_q;
	logic [63:0] r_q;
	logic [6:0]  cnt_q;
	logic [64:0] r_sh;
	logic [64:0] r_sub;
	logic        qbit;
	logic [63:0] r_next;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		r_sh   = {r_q, n_q[63]};
		r_sub  = r_sh - {1'b0, d_q};
		qbit   = (r_sh >= {1'b0, d_q});
		r_next = qbit ? r_sub[63:0] : r_sh[63:0];
	end

	assign done = (cnt_q == 7'd1);
	assign quo  = {n_q[62:0], qbit};
	assign rem  = r_next;

	// Load operands on start, then advance one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			n_q <= quo;
			r_q <= r_next;
		end
	end

endmodule

>>> hw/rtl/anlp_dp.sv
// ----------------------------------------------------------------------------
// anlp_dp
// Datapath: digit accumulators, scaling registers around the shared divider
// and the saturating output register.
// ----------------------------------------------------------------------------
module anlp_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  anlp_pkg::dp_cmd_t       cmd,
	output anlp_pkg::dp_stat_t      stat,
	output logic [1:0]              kind,
	output logic signed [31:0]      int_value,
	output logic signed [47:0]      fixed_value
);

	logic [31:0] int_acc_q;
	logic [31:0] frac_acc_q;
	logic [3:0]  frac_cnt_q;
	logic [7:0]  exp_acc_q;

	logic [63:0] q_q;
	logic [31:0] r_q;
	logic [63:0] whole_q;
	logic [63:0] fix_q;
	anlp_pkg::div_sel_t sel_q;

	logic [36:0] int_v;
	logic [36:0] frac_v;
	logic [12:0] exp_v;
	logic [36:0] int_lim;
	logic [63:0] pw_frac;
	logic [63:0] pw_exp;
	logic [63:0] div_num;
	logic [63:0] div_den;
	logic        div_done;
	logic [63:0] div_quo;
	logic [63:0] div_rem;
	logic [63:0] whole_s;
	logic [63:0] fix_s;

	// Next accumulator values for one digit
	always_comb begin
		int_v   = 37'(int_acc_q) * 37'(cmd.radix) + 37'(cmd.digit);
		frac_v  = 37'(frac_acc_q) * 37'(cmd.radix) + 37'(cmd.digit);
		exp_v   = 13'(exp_acc_q) * 13'(cmd.radix) + 13'(cmd.digit);
		int_lim = cmd.neg ? 37'h0080000000 : 37'h007FFFFFFF;
	end

	assign pw_frac = anlp_pkg::pow10({1'b0, frac_cnt_q});
	assign pw_exp  = anlp_pkg::pow10(exp_acc_q[4:0]);

	// Pick divider operands
	always_comb begin
		div_num = 64'(frac_acc_q);
		div_den = pw_frac;
		unique case (cmd.div_sel)
			anlp_pkg::SEL_FRAC:  div_num = 64'(frac_acc_q);
			anlp_pkg::SEL_R10:   div_num = (64'(r_q) << 3) + (64'(r_q) << 1);
			anlp_pkg::SEL_FIXF:  div_num = 64'(r_q) << 16;
			anlp_pkg::SEL_WHOLE: begin
				div_num = q_q;
				div_den = pw_exp;
			end
			anlp_pkg::SEL_FIX: begin
				div_num = fix_q;
				div_den = pw_exp;
			end
			default: div_num = 64'(frac_acc_q);
		endcase
	end

	anlp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign stat.div_done = div_done;
	assign stat.frac_nz  = (frac_acc_q != '0);
	assign stat.q_ge_cap = |q_q[63:40];
	assign stat.exp_val  = exp_acc_q[4:0];

	// Accumulate digits; clear after each literal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_acc_q  <= '0;
			frac_acc_q <= '0;
			frac_cnt_q <= '0;
			exp_acc_q  <= '0;
		end else if (cmd.clear) begin
			int_acc_q  <= '0;
			frac_acc_q <= '0;
			frac_cnt_q <= '0;
			exp_acc_q  <= '0;
		end else begin
			if (cmd.add_int) begin
				int_acc_q <= (int_v > int_lim) ? int_lim[31:0] : int_v[31:0];
			end
			if (cmd.add_frac && (32'(frac_cnt_q) < anlp_pkg::FRAC_DIGITS_MAX)) begin
				frac_acc_q <= (|frac_v[36:32]) ? 32'hFFFFFFFF : frac_v[31:0];
				frac_cnt_q <= frac_cnt_q + 4'd1;
			end
			if (cmd.add_exp) begin
				exp_acc_q <= (32'(exp_v) > anlp_pkg::EXP_LIMIT) ?
					8'(anlp_pkg::EXP_LIMIT) : exp_v[7:0];
			end
		end
	end

	// Hold the operand selection, apply the divider result when it lands
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
		end
		if (div_done) begin
			unique case (sel_q)
				anlp_pkg::SEL_FRAC: begin
					q_q <= 64'(int_acc_q) + div_quo;
					r_q <= div_rem[31:0];
				end
				anlp_pkg::SEL_R10: begin
					q_q <= (q_q << 3) + (q_q << 1) + div_quo;
					r_q <= div_rem[31:0];
				end
				anlp_pkg::SEL_FIXF: begin
					fix_q   <= (q_q << 16) + div_quo;
					whole_q <= q_q;
				end
				anlp_pkg::SEL_WHOLE: whole_q <= div_quo;
				anlp_pkg::SEL_FIX:   fix_q <= div_quo;
				default:             whole_q <= whole_q;
			endcase
		end
	end

	// Saturate to the signed output ranges
	always_comb begin
		if (cmd.neg) begin
			whole_s = (whole_q > 64'h80000000) ? 64'h80000000 : whole_q;
			fix_s   = (fix_q > 64'h800000000000) ? 64'h800000000000 : fix_q;
		end else begin
			whole_s = (whole_q > 64'h7FFFFFFF) ? 64'h7FFFFFFF : whole_q;
			fix_s   = (fix_q > 64'h7FFFFFFFFFFF) ? 64'h7FFFFFFFFFFF : fix_q;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_err) begin
				kind        <= anlp_pkg::KIND_ERR;
				int_value   <= '0;
				fixed_value <= '0;
			end else begin
				kind        <= stat.frac_nz ? anlp_pkg::KIND_FIX : anlp_pkg::KIND_INT;
				int_value   <= cmd.neg ? -$signed(whole_s[31:0]) : $signed(whole_s[31:0]);
				fixed_value <= cmd.neg ? -$signed(fix_s[47:0]) : $signed(fix_s[47:0]);
			end
		end
	end

endmodule

>>> hw/rtl/anlp_ctrl.sv
// ----------------------------------------------------------------------------
// anlp_ctrl
// Controller: literal grammar per character and sequencing of the scaling
// steps at the terminator.
// ----------------------------------------------------------------------------
module anlp_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              ch,
	output logic                    out_valid,
	input  logic                    out_ready,
	output anlp_pkg::dp_cmd_t       cmd,
	input  anlp_pkg::dp_stat_t      stat
);

	typedef enum logic [2:0] {
		PH_START, PH_ZERO, PH_INT_OPEN, PH_INT, PH_FRAC, PH_EXP_OPEN, PH_EXP
	} phase_t;

	typedef enum logic [2:0] {
		ST_CHAR, ST_FRAC, ST_LOOP, ST_R10, ST_FIXF, ST_WHOLE, ST_FIX, ST_PUT
	} state_t;

	state_t     state_q;
	phase_t     phase_q;
	logic [4:0] radix_q;
	logic       vneg_q;
	logic       eneg_q;
	logic       dseen_q;
	logic       bad_q;
	logic       err_q;
	logic [4:0] iter_q;

	phase_t     ph;
	logic [4:0] rdx;
	logic       vneg;
	logic       eneg;
	logic       dseen;
	logic       bad;
	logic       fin;
	logic       open;
	logic [6:0] dval;
	logic       sign;
	logic       isdig;
	logic       ise;
	logic       is_e;
	logic       add_int_c;
	logic       add_frac_c;
	logic       add_exp_c;
	logic       acc;
	logic       take_ch;
	logic       nul_acc;
	logic       ok;
	logic       put_go;
	logic       loop_end;

	// Character to digit value; 99 marks no digit
	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [6:0] d;
		if (c >= "0" && c <= "9") d = 7'(c - "0");
		else if (c >= "a" && c <= "z") d = 7'(c - "a") + 7'd10;
		else if (c >= "A" && c <= "Z") d = 7'(c - "A") + 7'd10;
		else d = 7'd99;
		return d;
	endfunction

	assign in_ready = (state_q == ST_CHAR);
	assign acc      = in_valid && in_ready;
	assign take_ch  = acc && (ch != 8'd0) && !bad_q;
	assign nul_acc  = acc && (ch == 8'd0);
	assign put_go   = (state_q == ST_PUT) && (!out_valid || out_ready);
	assign loop_end = eneg_q || (iter_q == stat.exp_val) || stat.q_ge_cap;
	assign ok = !bad_q && ((phase_q == PH_ZERO) ||
		((phase_q == PH_INT || phase_q == PH_FRAC || phase_q == PH_EXP) && dseen_q));

	// Grammar step for one character
	always_comb begin
		ph    = phase_q;
		rdx   = radix_q;
		vneg  = vneg_q;
		eneg  = eneg_q;
		dseen = dseen_q;
		bad   = bad_q;
		fin   = 1'b0;
		open  = 1'b0;
		add_int_c  = 1'b0;
		add_frac_c = 1'b0;
		add_exp_c  = 1'b0;
		dval  = digit_of(ch);
		sign  = (ch == "+") || (ch == "-");
		is_e  = (ch == "e") || (ch == "E");
		if (ph == PH_START) begin
			if (ch == "0") begin
				ph  = PH_ZERO;
				fin = 1'b1;
			end else begin
				ph = PH_INT_OPEN;
			end
		end
		if (!fin && ph == PH_ZERO) begin
			if (ch == "b" || ch == "B") begin
				rdx = 5'd2;
				ph  = PH_INT_OPEN;
				fin = 1'b1;
			end else if (ch == "x" || ch == "X") begin
				rdx = 5'd16;
				ph  = PH_INT_OPEN;
				fin = 1'b1;
			end else if (ch >= "0" && ch <= "7") begin
				rdx = 5'd8;
				ph  = PH_INT;
			end else if (is_e) begin
				ph  = PH_EXP_OPEN;
				fin = 1'b1;
			end else if (ch == ".") begin
				ph  = PH_FRAC;
				fin = 1'b1;
			end else begin
				bad = 1'b1;
				fin = 1'b1;
			end
		end
		isdig = (dval < 7'(rdx));
		ise   = !isdig && is_e;
		if (!fin && ph == PH_INT_OPEN) begin
			open = 1'b1;
			ph   = PH_INT;
			if (sign) begin
				vneg = (ch == "-");
				fin  = 1'b1;
			end
		end
		if (!fin && ph == PH_INT) begin
			fin = 1'b1;
			if (isdig) begin
				add_int_c = 1'b1;
				dseen = 1'b1;
			end else if ((dseen || open) && ch == ".") begin
				ph    = PH_FRAC;
				dseen = 1'b0;
			end else if ((dseen || open) && ise) begin
				ph    = PH_EXP_OPEN;
				dseen = 1'b0;
			end else begin
				bad = 1'b1;
			end
		end
		if (!fin && ph == PH_FRAC) begin
			fin = 1'b1;
			if (isdig) begin
				add_frac_c = 1'b1;
				dseen = 1'b1;
			end else if (ise) begin
				ph    = PH_EXP_OPEN;
				dseen = 1'b0;
			end else begin
				bad = 1'b1;
			end
		end
		if (!fin && ph == PH_EXP_OPEN) begin
			ph = PH_EXP;
			if (sign) begin
				eneg = (ch == "-");
				fin  = 1'b1;
			end
		end
		if (!fin && ph == PH_EXP) begin
			fin = 1'b1;
			if (isdig) begin
				add_exp_c = 1'b1;
				dseen = 1'b1;
			end else begin
				bad = 1'b1;
			end
		end
		if (!fin) begin
			bad = 1'b1;
		end
		if (!take_ch) begin
			add_int_c  = 1'b0;
			add_frac_c = 1'b0;
			add_exp_c  = 1'b0;
		end
	end

	// Datapath commands
	always_comb begin
		cmd.add_int   = add_int_c;
		cmd.add_frac  = add_frac_c;
		cmd.add_exp   = add_exp_c;
		cmd.digit     = dval[4:0];
		cmd.radix     = rdx;
		cmd.neg       = (state_q == ST_CHAR) ? vneg : vneg_q;
		cmd.clear     = put_go;
		cmd.out_load  = put_go;
		cmd.out_err   = err_q;
		cmd.div_start = 1'b0;
		cmd.div_sel   = anlp_pkg::SEL_FRAC;
		unique case (state_q)
			ST_CHAR: cmd.div_start = nul_acc && ok;
			ST_LOOP: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = loop_end ? anlp_pkg::SEL_FIXF : anlp_pkg::SEL_R10;
			end
			ST_FIXF: begin
				cmd.div_start = stat.div_done && eneg_q;
				cmd.div_sel   = anlp_pkg::SEL_WHOLE;
			end
			ST_WHOLE: begin
				cmd.div_start = stat.div_done;
				cmd.div_sel   = anlp_pkg::SEL_FIX;
			end
			default: cmd.div_start = 1'b0;
		endcase
	end

	// State, grammar registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CHAR;
			phase_q   <= PH_START;
			radix_q   <= 5'd10;
			vneg_q    <= 1'b0;
			eneg_q    <= 1'b0;
			dseen_q   <= 1'b0;
			bad_q     <= 1'b0;
			err_q     <= 1'b0;
			iter_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			// Raise valid on a new result, drop it once the transfer is done
			if (put_go) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CHAR: begin
					if (take_ch) begin
						phase_q <= ph;
						radix_q <= rdx;
						vneg_q  <= vneg;
						eneg_q  <= eneg;
						dseen_q <= dseen;
						bad_q   <= bad;
					end else if (nul_acc) begin
						err_q   <= !ok;
						iter_q  <= '0;
						state_q <= ok ? ST_FRAC : ST_PUT;
					end
				end
				ST_FRAC: if (stat.div_done) state_q <= ST_LOOP;
				ST_LOOP: begin
					if (loop_end) begin
						state_q <= ST_FIXF;
					end else begin
						iter_q  <= iter_q + 5'd1;
						state_q <= ST_R10;
					end
				end
				ST_R10: if (stat.div_done) state_q <= ST_LOOP;
				ST_FIXF: if (stat.div_done) state_q <= eneg_q ? ST_WHOLE : ST_PUT;
				ST_WHOLE: if (stat.div_done) state_q <= ST_FIX;
				ST_FIX: if (stat.div_done) state_q <= ST_PUT;
				ST_PUT: begin
					if (put_go) begin
						phase_q   <= PH_START;
						radix_q   <= 5'd10;
						vneg_q    <= 1'b0;
						eneg_q    <= 1'b0;
						dseen_q   <= 1'b0;
						bad_q     <= 1'b0;
						state_q   <= ST_CHAR;
					end
				end
				default: state_q <= ST_CHAR;
			endcase
		end
	end

endmodule

>>> tb/tb_ascii_number_literal_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_number_literal_parser_core
// Streams ASCII literals into the parser and checks every terminator result
// (kind, integer and Q31.16 values) against a cycle-free software predictor.
// ----------------------------------------------------------------------------
module tb_ascii_number_literal_parser_core;

	localparam int PH_START    = 0;
	localparam int PH_ZERO     = 1;
	localparam int PH_INT_OPEN = 2;
	localparam int PH_INT      = 3;
	localparam int PH_FRAC     = 4;
	localparam int PH_EXP_OPEN = 5;
	localparam int PH_EXP      = 6;
	localparam int IDLE_LIMIT  = 20000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] int_value;
		logic [47:0] fixed_value;
	} lit_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  ch;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic signed [31:0] int_value;
	logic signed [47:0] fixed_value;

	lit_result_t pending_results[$];
	int          error_count;
	int          idle_cycles;
	bit          stall_enable;

	// parser state of the predictor
	int          p_phase;
	int          p_radix;
	longint unsigned p_int;
	bit          p_neg;
	longint unsigned p_frac;
	int          p_fcount;
	int          p_exp;
	bit          p_eneg;
	bit          p_digit;
	bit          p_bad;

	ascii_number_literal_parser_core u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .ch(ch),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.int_value(int_value), .fixed_value(fixed_value)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic longint unsigned ten_pow(int n);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < n; i++) p = p * 10;
		return p;
	endfunction

	function automatic int char_digit(byte unsigned c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "z") return c - "a" + 10;
		if (c >= "A" && c <= "Z") return c - "A" + 10;
		return 99;
	endfunction

	task automatic clear_parse();
		p_phase = PH_START; p_radix = 10; p_int = 0; p_neg = 0; p_frac = 0;
		p_fcount = 0; p_exp = 0; p_eneg = 0; p_digit = 0; p_bad = 0;
	endtask

	// advance the predictor by one non-terminator character
	task automatic parse_char(byte unsigned c);
		bit open, isdig, ise, sgn;
		int d;
		longint unsigned v, lim;
		open = 0;
		sgn = (c == "+" || c == "-");
		d = char_digit(c);
		if (p_phase == PH_START) begin
			if (c == "0") begin
				p_phase = PH_ZERO;
				return;
			end
			p_phase = PH_INT_OPEN;
		end
		if (p_phase == PH_ZERO) begin
			if (c == "b" || c == "B") begin
				p_radix = 2; p_phase = PH_INT_OPEN; return;
			end
			if (c == "x" || c == "X") begin
				p_radix = 16; p_phase = PH_INT_OPEN; return;
			end
			if (c >= "0" && c <= "7") begin
				p_radix = 8; p_phase = PH_INT;
			end else if (c == "e" || c == "E") begin
				p_phase = PH_EXP_OPEN; return;
			end else if (c == ".") begin
				p_phase = PH_FRAC; return;
			end else begin
				p_bad = 1; return;
			end
		end
		isdig = d < p_radix;
		ise = !isdig && (c == "e" || c == "E");
		if (p_phase == PH_INT_OPEN) begin
			open = 1;
			p_phase = PH_INT;
			if (sgn) begin
				p_neg = (c == "-");
				return;
			end
		end
		if (p_phase == PH_INT) begin
			if (isdig) begin
				lim = p_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
				v = p_int * p_radix + d;
				p_int = (v > lim) ? lim : v;
				p_digit = 1;
			end else if ((p_digit || open) && c == ".") begin
				p_phase = PH_FRAC; p_digit = 0;
			end else if ((p_digit || open) && ise) begin
				p_phase = PH_EXP_OPEN; p_digit = 0;
			end else p_bad = 1;
			return;
		end
		if (p_phase == PH_FRAC) begin
			if (isdig) begin
				if (p_fcount < anlp_pkg::FRAC_DIGITS_MAX) begin
					v = p_frac * p_radix + d;
					p_frac = (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
					p_fcount++;
				end
				p_digit = 1;
			end else if (ise) begin
				p_phase = PH_EXP_OPEN; p_digit = 0;
			end else p_bad = 1;
			return;
		end
		if (p_phase == PH_EXP_OPEN) begin
			p_phase = PH_EXP;
			if (sgn) begin
				p_eneg = (c == "-");
				return;
			end
		end
		if (p_phase == PH_EXP) begin
			if (isdig) begin
				v = p_exp * p_radix + d;
				p_exp = (v > anlp_pkg::EXP_LIMIT) ? int'(anlp_pkg::EXP_LIMIT) : int'(v);
				p_digit = 1;
			end else p_bad = 1;
			return;
		end
		p_bad = 1;
	endtask

	// compute the terminator result from the predictor state
	function automatic lit_result_t scale_literal();
		lit_result_t res;
		bit ok;
		longint unsigned den, q, r, r10, whole, fix, p;
		ok = !p_bad && (p_phase == PH_ZERO || ((p_phase == PH_INT || p_phase == PH_FRAC ||
			p_phase == PH_EXP) && p_digit));
		res = '0;
		if (!ok) return res;
		den = ten_pow(p_fcount);
		q = p_int + p_frac / den;
		r = p_frac % den;
		if (!p_eneg) begin
			for (int i = 0; i < p_exp; i++) begin
				if (q >= (64'd1 << 40)) break;
				r10 = r * 10;
				q = q * 10 + r10 / den;
				r = r10 % den;
			end
			whole = q;
			fix = (q << 16) + (r << 16) / den;
		end else begin
			p = ten_pow(p_exp);
			whole = q / p;
			fix = ((q << 16) + (r << 16) / den) / p;
		end
		if (p_neg) begin
			if (whole > 64'h8000_0000) whole = 64'h8000_0000;
			if (fix > 64'h8000_0000_0000) fix = 64'h8000_0000_0000;
			whole = 64'd0 - whole;
			fix = 64'd0 - fix;
		end else begin
			if (whole > 64'h7FFF_FFFF) whole = 64'h7FFF_FFFF;
			if (fix > 64'h7FFF_FFFF_FFFF) fix = 64'h7FFF_FFFF_FFFF;
		end
		res.kind = (p_frac != 0) ? anlp_pkg::KIND_FIX : anlp_pkg::KIND_INT;
		res.int_value = whole[31:0];
		res.fixed_value = fix[47:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		error_count++;
	endtask

	// send one character; valid stays high within a burst, random gap first
	task automatic send_char(byte unsigned c, bit gappy = 1);
		if (gappy && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (c == 8'd0)
			pending_results.push_back(scale_literal());
		if (c == 8'd0) clear_parse();
		else if (!p_bad) parse_char(c);
		@(negedge clk);
	endtask

	task automatic send_literal(string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
		send_char(8'd0);
	endtask

	// drop valid and hold until every predicted result has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	// check each result transfer against the oldest prediction
	always @(posedge clk) begin
		lit_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result kind", 64'(kind), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", 64'(kind), 64'(want.kind));
				if (int_value !== want.int_value)
					report_mismatch("int_value", 64'(int_value), 64'(want.int_value));
				if (fixed_value !== want.fixed_value)
					report_mismatch("fixed_value", 64'(fixed_value),
						64'(want.fixed_value));
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (!stall_enable) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic test_directed();
		string lits[$];
		lits = '{"0", "", "0x", "0b", "-", "+", "-5", "+0x1F", "017", "018", "0.5", "0e3",
			".5", "e3", "5.e3", "5.", "1.-2", "1e", "1e+", "1.e", "1 2", "0b1012",
			"99999999999", "-2147483648", "1.0000000000123", "1e99", "0xFFe1",
			"3.25e-2", "0x1.8", "0b-1.1e11", "-0.001", "0B1.1E+1"};
		foreach (lits[i]) send_literal(lits[i]);
		wait_drained();
	endtask

	function automatic byte unsigned rand_digit(int radix);
		int d;
		d = $urandom_range(0, radix - 1);
		return (d < 10) ? byte'("0" + d) : byte'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
	endfunction

	// mostly well-formed literals with random content, plus noise
	task automatic test_random(int n_items);
		int sent, radix, len;
		string s;
		sent = 0;
		while (sent < n_items) begin
			s = "";
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(0, 8);
				for (int i = 0; i < len; i++)
					s = {s, string'(byte'($urandom_range(1, 255)))};
			end else begin
				case ($urandom_range(0, 3))
					0: begin radix = 2;  s = string'($urandom_range(0, 1) ? "0b" : "0B"); end
					1: begin radix = 16; s = string'($urandom_range(0, 1) ? "0x" : "0X"); end
					2: begin radix = 8;  s = "0"; end
					default: radix = 10;
				endcase
				if (radix != 8 && $urandom_range(0, 2) == 0)
					s = {s, string'($urandom_range(0, 1) ? "-" : "+")};
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
				for (int i = 0; i < len; i++) s = {s, string'(rand_digit(radix))};
				if (radix == 8) s = {s, string'(byte'("0" + $urandom_range(0, 7)))};
				if ($urandom_range(0, 1)) begin
					s = {s, "."};
					len = $urandom_range(0, 12);
					for (int i = 0; i < len; i++) s = {s, string'(rand_digit(radix))};
				end
				if (radix != 16 && $urandom_range(0, 2) == 0) begin
					s = {s, string'($urandom_range(0, 1) ? "e" : "E")};
					if ($urandom_range(0, 1))
						s = {s, string'($urandom_range(0, 1) ? "-" : "+")};
					len = $urandom_range(0, 3);
					for (int i = 0; i < len; i++) s = {s, string'(rand_digit(radix))};
				end
				if ($urandom_range(0, 19) == 0)
					s = {s, string'(byte'($urandom_range(1, 255)))};
			end
			send_literal(s);
			sent += s.len() + 1;
			if ($urandom_range(0, 99) == 0) wait_drained();
		end
	endtask

	// full sweep of every nonzero byte, high-bit characters included, as noise
	task automatic test_byte_sweep();
		for (int c = 1; c < 256; c++) begin
			send_char(byte'(c), 0);
			send_char(8'd0, 0);
		end
	endtask

	initial begin
		in_valid = 1'b0;
		ch = 8'd0;
		out_ready = 1'b1;
		stall_enable = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		clear_parse();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		stall_enable = 1'b1;
		test_byte_sweep();
		wait_drained();
		test_random(800);
		wait_drained();
		repeat (2000) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
